// ===== src/dra_pkg.sv =====
// Shared types and constants for the divider resistance averager.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package dra_pkg;

  localparam int SAMPLE_W = 12;
  localparam int REF_W = 16;
  localparam int LIMIT_W = 24;
  localparam int RES_W = 24;
  localparam int PROD_W = REF_W + SAMPLE_W;
  localparam int VALUE_W = PROD_W - 1;
  localparam int DEN_W = SAMPLE_W;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_LIMIT = 8'd1;

  localparam logic [REF_W-1:0] REFERENCE_RESET = 16'd6000;
  localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RESET = 24'd3000000;

  localparam logic [SAMPLE_W-1:0] MIN_SENSOR = 12'd3;
  localparam logic [SAMPLE_W:0] SHORT_MARGIN = 13'd3;

  localparam int DEF_SAMPLES_PER_BLOCK = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_SHORT,
    KIND_OPEN
  } pair_kind_t;

  typedef struct packed {
    pair_kind_t kind;
    logic [PROD_W-1:0] product;
    logic [SAMPLE_W-1:0] sensor;
  } dra_item_t;

endpackage
`default_nettype wire

// ===== src/dra_queue.sv =====
// Short queue of classified pairs between the front and back parts.
// Uses dra_pkg for the entry type and queue depth.
`default_nettype none
module dra_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dra_pkg::dra_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output dra_pkg::dra_item_t     pop_item,
  output logic                   empty
);
  import dra_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dra_item_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/dra_front.sv =====
// Input side: accepts sample pairs, classifies them and forms the product.
// Uses dra_pkg; feeds dra_queue.
`default_nettype none
module dra_front (
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [dra_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [dra_pkg::REF_W-1:0]    reference_ohms,
  input  wire logic                         queue_full,
  output logic                              push,
  output dra_pkg::dra_item_t                push_item
);
  import dra_pkg::*;

  logic [SAMPLE_W-1:0] supply;
  logic [SAMPLE_W-1:0] sensor;
  logic [SAMPLE_W-1:0] diff;
  logic [PROD_W-1:0] product;

  assign supply = s_tdata[SAMPLE_W-1:0];
  assign sensor = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign diff = supply - sensor;
  assign product = PROD_W'(reference_ohms) * PROD_W'(diff);

  assign s_tready = !queue_full;
  assign push = s_tvalid && !queue_full;

  always_comb begin
    push_item.product = product;
    push_item.sensor = sensor;
    if (sensor < MIN_SENSOR) begin
      push_item.kind = KIND_OPEN;
    end else if ({1'b0, supply} <= ({1'b0, sensor} + SHORT_MARGIN)) begin
      push_item.kind = KIND_SHORT;
    end else begin
      push_item.kind = KIND_NORMAL;
    end
  end

endmodule
`default_nettype wire

// ===== src/dra_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses dra_pkg for the divisor width; serves the per-pair division in dra_back.
`default_nettype none
module dra_div #(
  parameter int NUM_W = 28
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [NUM_W-1:0]           num,
  input  wire logic [dra_pkg::DEN_W-1:0]  den,
  output logic                            done,
  output logic [NUM_W-1:0]                quotient
);
  import dra_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] divisor;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic busy;
  logic [DEN_W:0] trial;
  logic fits;

  assign trial = {rem, quotient[NUM_W-1]};
  assign fits = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= den;
      rem <= '0;
      quotient <= num;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/dra_back.sv =====
// Back part: per-pair division, block sum, block mean, clamp and smoothing.
// Uses dra_pkg and dra_div; drains dra_queue and drives the output register.
`default_nettype none
module dra_back #(
  parameter int SAMPLES_PER_BLOCK = dra_pkg::DEF_SAMPLES_PER_BLOCK
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           queue_empty,
  input  wire dra_pkg::dra_item_t             pop_item,
  output logic                                pop,
  input  wire logic [dra_pkg::LIMIT_W-1:0]    open_limit_ohms,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [dra_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import dra_pkg::*;

  localparam int LOG_N = $clog2(SAMPLES_PER_BLOCK);
  localparam int SUM_W = VALUE_W + LOG_N;
  localparam int COUNT_W = $clog2(SAMPLES_PER_BLOCK + 1);
  localparam int MEAN_IN_W = RES_W + LOG_N;
  localparam int RECIP_SHIFT = MEAN_IN_W + LOG_N;
  localparam int RECIP_W = MEAN_IN_W + 1;
  localparam int MPROD_W = MEAN_IN_W + RECIP_W;
  localparam int CMP_W = (SUM_W > MEAN_IN_W + 1) ? SUM_W : MEAN_IN_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR_DIV,
    ST_ACCUM,
    ST_MEAN,
    ST_EMIT
  } state_t;

  state_t state;
  logic [VALUE_W-1:0] value;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [COUNT_W-1:0] count;
  logic [RES_W-1:0] mean;
  logic [RES_W-1:0] running_average;
  logic [RES_W-1:0] running_average_next;
  logic average_loaded;
  logic div_start;
  logic [PROD_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic div_done;
  logic [PROD_W-1:0] div_quotient;
  logic [RES_W:0] avg_sum;
  logic out_free;
  logic [CMP_W-1:0] mean_bound;
  logic mean_over;
  logic [MPROD_W-1:0] mean_product;

  dra_div #(
    .NUM_W(PROD_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quotient(div_quotient)
  );

  assign pop = (state == ST_IDLE) && !queue_empty;
  assign sum_next = sum + SUM_W'(value);
  assign avg_sum = {1'b0, mean} + {1'b0, running_average};
  assign running_average_next = average_loaded ? avg_sum[RES_W:1] : mean;
  assign out_free = !m_tvalid || m_tready;

  // The mean exceeds the limit exactly when the sum reaches N * (limit + 1). Below that
  // bound the sum fits MEAN_IN_W bits and a rounded-up reciprocal gives the exact quotient.
  assign mean_bound = (CMP_W'(open_limit_ohms) + CMP_W'(1)) * CMP_W'(SAMPLES_PER_BLOCK);
  assign mean_over = (CMP_W'(sum) >= mean_bound);
  assign mean_product = MPROD_W'(sum[MEAN_IN_W-1:0]) * MPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum <= '0;
      count <= '0;
      running_average <= '0;
      average_loaded <= 1'b0;
      div_start <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            case (pop_item.kind)
              KIND_OPEN: begin
                value <= VALUE_W'(open_limit_ohms);
                state <= ST_ACCUM;
              end
              KIND_SHORT: begin
                value <= VALUE_W'(1);
                state <= ST_ACCUM;
              end
              default: begin
                div_start <= 1'b1;
                div_num <= pop_item.product;
                div_den <= pop_item.sensor;
                state <= ST_PAIR_DIV;
              end
            endcase
          end
        end
        ST_PAIR_DIV: begin
          if (div_done) begin
            value <= VALUE_W'(div_quotient);
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          sum <= sum_next;
          if (count == COUNT_W'(SAMPLES_PER_BLOCK - 1)) begin
            count <= '0;
            state <= ST_MEAN;
          end else begin
            count <= count + 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_MEAN: begin
          if (mean_over) begin
            mean <= open_limit_ohms;
          end else begin
            mean <= mean_product[RECIP_SHIFT +: RES_W];
          end
          sum <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tdata <= {running_average_next, mean};
            m_tvalid <= 1'b1;
            running_average <= running_average_next;
            average_loaded <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/divider_resistance_averager_core.sv =====
// Top level of the divider resistance averager: config registers, front, queue, back.
// Depends on dra_pkg, dra_front, dra_queue and dra_back.
// A normal pair holds the back part while the one-bit-per-cycle divider works through its
// 28 quotient bits; a short or open pair skips the divider, and a block's last pair also
// passes the mean and emit states, where the result word waits until the output is free.
// Synchronous reset clears the sums, the running average and the queue, and reloads both registers.
`default_nettype none
module divider_resistance_averager_core #(
  parameter int SAMPLES_PER_BLOCK = dra_pkg::DEF_SAMPLES_PER_BLOCK
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: supply_sample [11:0], sensor_sample [23:12]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [dra_pkg::IN_DATA_W-1:0]    s_tdata,
  // m_tdata: block_resistance [23:0], smoothed_resistance [47:24]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [dra_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dra_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [dra_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dra_pkg::*;

  logic [REF_W-1:0] reference_ohms;
  logic [LIMIT_W-1:0] open_limit_ohms;
  logic push;
  dra_item_t push_item;
  logic queue_full;
  logic pop;
  dra_item_t pop_item;
  logic queue_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms <= REFERENCE_RESET;
      open_limit_ohms <= OPEN_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_REFERENCE) begin
        reference_ohms <= cfg_data[REF_W-1:0];
      end else if (cfg_index == REG_OPEN_LIMIT) begin
        open_limit_ohms <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  dra_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .reference_ohms(reference_ohms),
    .queue_full(queue_full),
    .push(push),
    .push_item(push_item)
  );

  dra_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(queue_full),
    .pop(pop),
    .pop_item(pop_item),
    .empty(queue_empty)
  );

  dra_back #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .queue_empty(queue_empty),
    .pop_item(pop_item),
    .pop(pop),
    .open_limit_ohms(open_limit_ohms),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire
